// ----- hdl/lrupr_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement package
// Request and response payloads, operation and status codes, and the
// command group between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

  localparam int unsigned PAGE_NUMBER_BITS = 27;

  typedef enum logic [1:0] {
    OP_ACCESS = 2'd0,
    OP_MAP    = 2'd1,
    OP_EVICT  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef logic [PAGE_NUMBER_BITS-1:0] page_t;

  typedef struct packed {
    logic [1:0] operation;
    page_t      page_number;
  } req_t;

  typedef struct packed {
    logic    hit;
    page_t   victim_page;
    status_e status;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hdl/lru_page_replacement_core.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement core
// Keeps resident pages in recency order; access, map and evict requests.
// ----------------------------------------------------------------------------
// An accepted request is compared, then updated once the response register is free.
// A new request is taken only in idle, after the last one ends its load/compare/update sequence.
// The response register lets a new request be taken while a response waits.
// Reset: asynchronous, active low; clears occupancy and handshake state.
// Page slots are not cleared; only occupied slots are ever read.
`default_nettype none

module lru_page_replacement_core #(
  parameter int unsigned FRAMES = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire lrupr_pkg::req_t in_req_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output lrupr_pkg::rsp_t      out_rsp_o
);

  lrupr_pkg::cmd_t cmd;

  lrupr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  lrupr_datapath #(
    .FRAMES (FRAMES)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_req_i),
    .rsp_o  (out_rsp_o)
  );

endmodule

`default_nettype wire

// ----- hdl/lrupr_datapath.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement datapath
// Recency stack of page registers with parallel lookup, move-to-front,
// insert-at-front and evict from the tail, plus the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_datapath #(
  parameter int unsigned FRAMES = 8,
  localparam int unsigned CW = $clog2(FRAMES + 1)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lrupr_pkg::cmd_t cmd_i,
  input  wire lrupr_pkg::req_t req_i,
  output lrupr_pkg::rsp_t     rsp_o
);

  lrupr_pkg::req_t  req_q;
  lrupr_pkg::page_t slot_q [FRAMES];
  lrupr_pkg::page_t slot_d [FRAMES];
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [FRAMES-1:0] valid;
  logic [FRAMES-1:0] match_d, match_q;
  logic [FRAMES-1:0] hitmask_d, hitmask_q;
  logic [FRAMES-1:0] insmask;
  logic [FRAMES-1:0] shift;
  logic             front;
  logic             hit_q;
  lrupr_pkg::page_t victim_d, victim_q;
  lrupr_pkg::rsp_t  rsp_q, rsp_d;

  always_comb begin
    victim_d = '0;
    insmask  = '0;
    for (int i = 0; i < FRAMES; i++) begin
      valid[i]   = CW'(i) < cnt_q;
      match_d[i] = valid[i] && (slot_q[i] == req_q.page_number);
      if (cnt_q == CW'(i + 1)) begin
        victim_d = slot_q[i];
      end
    end
    for (int i = 0; i < FRAMES; i++) begin
      hitmask_d[i] = |(match_d >> i);
    end
    for (int i = 1; i < FRAMES; i++) begin
      insmask[i] = valid[i-1];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    rsp_d = rsp_q;
    shift = '0;
    front = 1'b0;
    if (cmd_i.update) begin
      rsp_d.hit         = 1'b0;
      rsp_d.victim_page = '0;
      rsp_d.status      = lrupr_pkg::ST_DONE;
      unique case (req_q.operation)
        lrupr_pkg::OP_ACCESS: begin
          if (hit_q) begin
            shift     = hitmask_q;
            front     = 1'b1;
            rsp_d.hit = 1'b1;
          end
        end
        lrupr_pkg::OP_MAP: begin
          if (hit_q) begin
            shift     = hitmask_q;
            front     = 1'b1;
            rsp_d.hit = 1'b1;
          end else if (cnt_q == CW'(FRAMES)) begin
            rsp_d.status = lrupr_pkg::ST_FULL;
          end else begin
            shift = insmask;
            front = 1'b1;
            cnt_d = cnt_q + CW'(1);
          end
        end
        lrupr_pkg::OP_EVICT: begin
          if (cnt_q == '0) begin
            rsp_d.status = lrupr_pkg::ST_EMPTY;
          end else begin
            cnt_d             = cnt_q - CW'(1);
            rsp_d.victim_page = victim_q;
          end
        end
        default: ;
      endcase
    end
    for (int i = 0; i < FRAMES; i++) begin
      slot_d[i] = slot_q[i];
    end
    for (int i = 1; i < FRAMES; i++) begin
      if (shift[i]) begin
        slot_d[i] = slot_q[i-1];
      end
    end
    if (front) begin
      slot_d[0] = req_q.page_number;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.compare) begin
      match_q   <= match_d;
      hitmask_q <= hitmask_d;
      hit_q     <= |match_d;
      victim_q  <= victim_d;
    end
    for (int i = 0; i < FRAMES; i++) begin
      slot_q[i] <= slot_d[i];
    end
    rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(FRAMES))
    else $error("occupancy exceeds frame count");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.compare |=> $onehot0(match_q))
    else $error("page held in more than one slot");

  a_evict_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update && req_q.operation == lrupr_pkg::OP_EVICT && cnt_q == '0
    |=> rsp_q.status == lrupr_pkg::ST_EMPTY && cnt_q == '0)
    else $error("evict on empty table mishandled");

endmodule

`default_nettype wire

// ----- hdl/lrupr_ctrl.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement controller
// Sequences each request through load, compare and update, and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output lrupr_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   fire;

  assign fire = (state_q == S_UPD) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (fire) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.load    = in_valid_i && in_ready_o;
  assign cmd_o.compare = (state_q == S_CMP);
  assign cmd_o.update  = fire;

  a_update_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> out_valid_o)
    else $error("response not presented after update");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |-> (!out_valid_q || out_ready_i))
    else $error("pending response overwritten");

  a_load_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.compare)
    else $error("accepted request not compared");

endmodule

`default_nettype wire
